FILE: src/mue_pkg.sv
// ----------------------------------------------------------------------------
// mue_pkg
// Shared types, character constants and the high-half code point table for
// the MacRoman to UTF-8 escaper.
// ----------------------------------------------------------------------------
package mue_pkg;

   localparam int RUN_MAX = 4;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [RUN_MAX-1:0][7:0] bytes;
      logic [1:0]              last_idx;
   } run_type;

   localparam byte_type CHAR_BACKSLASH = 8'h5C;
   localparam byte_type CHAR_DQUOTE    = 8'h22;
   localparam byte_type CHAR_DEL       = 8'h7F;
   localparam byte_type CHAR_SPACE     = 8'h20;
   localparam byte_type CHAR_NUL       = 8'h00;
   localparam byte_type CHAR_BEL       = 8'h07;
   localparam byte_type CHAR_BS        = 8'h08;
   localparam byte_type CHAR_TAB       = 8'h09;
   localparam byte_type CHAR_LF        = 8'h0A;
   localparam byte_type CHAR_VT        = 8'h0B;
   localparam byte_type CHAR_FF        = 8'h0C;
   localparam byte_type CHAR_CR        = 8'h0D;
   localparam byte_type LETTER_ZERO    = 8'h30;
   localparam byte_type LETTER_A       = 8'h61;
   localparam byte_type LETTER_B       = 8'h62;
   localparam byte_type LETTER_F       = 8'h66;
   localparam byte_type LETTER_N       = 8'h6E;
   localparam byte_type LETTER_R       = 8'h72;
   localparam byte_type LETTER_T       = 8'h74;
   localparam byte_type LETTER_V       = 8'h76;
   localparam byte_type LETTER_X       = 8'h78;

   localparam logic [1:0] LAST_ONE   = 2'd0;
   localparam logic [1:0] LAST_TWO   = 2'd1;
   localparam logic [1:0] LAST_THREE = 2'd2;
   localparam logic [1:0] LAST_FOUR  = 2'd3;

   localparam logic [15:0] CP_TABLE [0:127] = '{
      16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
      16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
      16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
      16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
      16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
      16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
      16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
      16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
      16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
      16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
      16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
      16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
      16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
      16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
      16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
      16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
   };

   function automatic byte_type hex_digit(input logic [3:0] nib);
      byte_type d;
      if (nib < 4'd10) begin
         d = {4'h3, nib};
      end else begin
         d = 8'h57 + {4'h0, nib};
      end
      return d;
   endfunction

endpackage

FILE: src/mue_front.sv
// ----------------------------------------------------------------------------
// mue_front
// Holds the escape control register and turns one input byte into a run of
// up to four output bytes with the index of its last byte.
// ----------------------------------------------------------------------------
module mue_front
   import mue_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_we,
   input  logic     csr_escape_enable,
   input  byte_type in_byte,
   output run_type  run
);

   logic        escape_ff;
   logic        escape_in;
   logic [15:0] cp;
   byte_type    letter;

   assign escape_in = csr_we ? csr_escape_enable : escape_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b1;
      end else begin
         escape_ff <= escape_in;
      end
   end

   assign cp = CP_TABLE[in_byte[6:0]];

   always_comb begin
      unique case (in_byte)
         CHAR_BACKSLASH: letter = CHAR_BACKSLASH;
         CHAR_DQUOTE:    letter = CHAR_DQUOTE;
         CHAR_LF:        letter = LETTER_N;
         CHAR_CR:        letter = LETTER_R;
         CHAR_TAB:       letter = LETTER_T;
         CHAR_NUL:       letter = LETTER_ZERO;
         CHAR_BEL:       letter = LETTER_A;
         CHAR_BS:        letter = LETTER_B;
         CHAR_FF:        letter = LETTER_F;
         CHAR_VT:        letter = LETTER_V;
         default:        letter = CHAR_NUL;
      endcase
   end

   always_comb begin
      run.bytes    = '0;
      run.last_idx = LAST_ONE;
      if (in_byte[7]) begin
         if (cp[15:11] == 5'd0) begin
            run.bytes[0] = {3'b110, cp[10:6]};
            run.bytes[1] = {2'b10, cp[5:0]};
            run.last_idx = LAST_TWO;
         end else begin
            run.bytes[0] = {4'b1110, cp[15:12]};
            run.bytes[1] = {2'b10, cp[11:6]};
            run.bytes[2] = {2'b10, cp[5:0]};
            run.last_idx = LAST_THREE;
         end
      end else if (escape_ff && (letter != CHAR_NUL)) begin
         run.bytes[0] = CHAR_BACKSLASH;
         run.bytes[1] = letter;
         run.last_idx = LAST_TWO;
      end else if (escape_ff && ((in_byte < CHAR_SPACE) || (in_byte == CHAR_DEL))) begin
         run.bytes[0] = CHAR_BACKSLASH;
         run.bytes[1] = LETTER_X;
         run.bytes[2] = hex_digit(in_byte[7:4]);
         run.bytes[3] = hex_digit(in_byte[3:0]);
         run.last_idx = LAST_FOUR;
      end else begin
         run.bytes[0] = in_byte;
      end
   end

endmodule

FILE: src/mue_queue.sv
// ----------------------------------------------------------------------------
// mue_queue
// Short queue of classified runs between the front and the back.
// ----------------------------------------------------------------------------
module mue_queue
   import mue_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  run_type push_run,
   output logic    full,
   input  logic    pop,
   output run_type pop_run,
   output logic    not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   run_type          store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_run   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_run;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

FILE: src/mue_back.sv
// ----------------------------------------------------------------------------
// mue_back
// Takes runs from the queue and hands out their bytes one word at a time,
// flagging the last byte of each run.
// ----------------------------------------------------------------------------
module mue_back
   import mue_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_not_empty,
   input  run_type  q_run,
   output logic     q_pop,
   output logic     empty,
   input  logic     pop,
   output byte_type out_byte,
   output logic     last_of_run
);

   logic       valid_ff, valid_in;
   run_type    run_ff, run_in;
   logic [1:0] idx_ff, idx_in;
   logic       take;
   logic       at_last;

   assign empty       = !valid_ff;
   assign at_last     = (idx_ff == run_ff.last_idx);
   assign take        = pop && valid_ff;
   assign out_byte    = run_ff.bytes[idx_ff];
   assign last_of_run = at_last;
   assign q_pop       = q_not_empty && (!valid_ff || (take && at_last));

   always_comb begin
      valid_in = valid_ff;
      run_in   = run_ff;
      idx_in   = idx_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         run_in   = q_run;
         idx_in   = '0;
      end else if (take) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff <= run_ff.last_idx))
      else $error("byte index past end of run");

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !pop) |=> (valid_ff && $stable(idx_ff) && $stable(run_ff)))
      else $error("stalled run changed");

endmodule

FILE: src/macroman_utf8_escaper_core.sv
// ----------------------------------------------------------------------------
// macroman_utf8_escaper_core
// Converts a MacRoman byte stream to UTF-8 with optional backslash escaping.
// One input byte is accepted per cycle while the run queue has room; each
// byte becomes a run of one to four output bytes, and the output side hands
// out one byte per cycle while the consumer pops, so the sustained input
// rate is one byte per cycle for one-byte runs and falls with longer runs,
// set by the single output byte port. The first output byte of a run passes
// through the run queue and the output register.
// ----------------------------------------------------------------------------
module macroman_utf8_escaper_core
   import mue_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   input  logic       csr_we,
   input  logic       csr_escape_enable
);

   run_type front_run;
   run_type q_run;
   logic    q_not_empty;
   logic    q_pop;

   mue_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_escape_enable (csr_escape_enable),
      .in_byte           (req_in_byte),
      .run               (front_run)
   );

   mue_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_run  (front_run),
      .full      (req_full),
      .pop       (q_pop),
      .pop_run   (q_run),
      .not_empty (q_not_empty)
   );

   mue_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_run       (q_run),
      .q_pop       (q_pop),
      .empty       (rsp_empty),
      .pop         (rsp_pop),
      .out_byte    (rsp_out_byte),
      .last_of_run (rsp_last_of_run)
   );

endmodule

FILE: bench/macroman_utf8_escaper_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macroman_utf8_escaper_core_tb
// Self-checking bench for the MacRoman to UTF-8 escaper. A scoreboard
// predicts the output word run of every accepted byte from its own code
// point table and escape rules. Every popped word is checked against the
// oldest prediction. Stimulus is a directed set of edge bytes, then random
// phases with escaping switched on and off, random idling on both sides,
// two phases with no idling, and long output hold-offs that back up the
// input.
// ----------------------------------------------------------------------------
package mue_tb_pkg;
   import mue_pkg::*;

   localparam logic [15:0] HIGH_HALF_CP [0:127] = '{
      16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
      16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
      16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
      16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
      16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
      16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
      16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
      16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
      16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
      16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
      16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
      16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
      16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
      16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
      16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
      16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
   };

   typedef struct packed {
      byte_type data;
      logic     last;
   } out_word_type;

   class run_scoreboard;
      out_word_type expected_words[$];
      int           mismatches;

      function new();
         mismatches = 0;
      endfunction

      function byte_type lower_hex(input logic [3:0] nib);
         byte_type d;
         if (nib < 4'd10) begin
            d = 8'h30 + {4'h0, nib};
         end else begin
            d = 8'h61 + {4'h0, nib} - 8'd10;
         end
         return d;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void add_source_byte(input byte_type b, input bit escape_on);
         byte_type    run[$];
         byte_type    letter;
         logic [15:0] cp;
         out_word_type w;
         if (b < 8'h80) begin
            if (!escape_on) begin
               run.push_back(b);
            end else begin
               case (b)
                  CHAR_BACKSLASH: letter = CHAR_BACKSLASH;
                  CHAR_DQUOTE:    letter = CHAR_DQUOTE;
                  CHAR_LF:        letter = LETTER_N;
                  CHAR_CR:        letter = LETTER_R;
                  CHAR_TAB:       letter = LETTER_T;
                  CHAR_NUL:       letter = LETTER_ZERO;
                  CHAR_BEL:       letter = LETTER_A;
                  CHAR_BS:        letter = LETTER_B;
                  CHAR_FF:        letter = LETTER_F;
                  CHAR_VT:        letter = LETTER_V;
                  default:        letter = CHAR_NUL;
               endcase
               if (letter != CHAR_NUL) begin
                  run.push_back(CHAR_BACKSLASH);
                  run.push_back(letter);
               end else if (b < CHAR_SPACE || b == CHAR_DEL) begin
                  run.push_back(CHAR_BACKSLASH);
                  run.push_back(LETTER_X);
                  run.push_back(lower_hex(b[7:4]));
                  run.push_back(lower_hex(b[3:0]));
               end else begin
                  run.push_back(b);
               end
            end
         end else begin
            cp = HIGH_HALF_CP[b[6:0]];
            if (cp < 16'h0800) begin
               run.push_back({3'b110, cp[10:6]});
               run.push_back({2'b10, cp[5:0]});
            end else begin
               run.push_back({4'b1110, cp[15:12]});
               run.push_back({2'b10, cp[11:6]});
               run.push_back({2'b10, cp[5:0]});
            end
         end
         foreach (run[k]) begin
            w.data = run[k];
            w.last = (k == run.size() - 1);
            expected_words.push_back(w);
         end
      endfunction

      task report(input string msg);
         $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      task check_out_word(input byte_type data, input logic last);
         out_word_type w;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word data=%02h last=%0b", data, last));
         end else begin
            w = expected_words.pop_front();
            if (data !== w.data) begin
               report($sformatf("data got %02h want %02h", data, w.data));
            end
            if (last !== w.last) begin
               report($sformatf("last got %0b want %0b (data %02h)", last, w.last, w.data));
            end
         end
      endtask
   endclass
endpackage

module macroman_utf8_escaper_core_tb;
   import mue_pkg::*;
   import mue_tb_pkg::*;

   localparam int IDLE_PCT     = 13;
   localparam int HOLD_CYCLES  = 80;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 8;

   logic     clock;
   logic     reset;
   logic     req_push;
   logic     req_full;
   byte_type req_in_byte;
   logic     rsp_empty;
   logic     rsp_pop;
   byte_type rsp_out_byte;
   logic     rsp_last_of_run;
   logic     csr_we;
   logic     csr_escape_enable;

   run_scoreboard sb;
   bit  escape_on;
   bit  calm;
   bit  hold_request;
   int  hold_left;
   int  stall_count;

   macroman_utf8_escaper_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_in_byte       (req_in_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_we            (csr_we),
      .csr_escape_enable (csr_escape_enable)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // output side: random pop, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         sb.check_out_word(rsp_out_byte, rsp_last_of_run);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_count = 0;
      end else begin
         stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic byte_type pick_byte();
      byte_type specials[12] = '{CHAR_BACKSLASH, CHAR_DQUOTE, CHAR_NUL, CHAR_BEL, CHAR_BS,
                                 CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR, CHAR_DEL,
                                 CHAR_SPACE};
      byte_type b;
      case ($urandom_range(9))
         0, 1, 2, 3: b = byte_type'($urandom_range(255));
         4, 5:       b = byte_type'($urandom_range(31));
         6:          b = specials[$urandom_range(11)];
         7:          b = byte_type'($urandom_range(255, 128));
         8:          b = byte_type'($urandom_range(126, 32));
         default:    b = byte_type'($urandom_range(255, 240));
      endcase
      return b;
   endfunction

   // offer one word, wait until it is taken; starts and ends at a falling edge
   task automatic push_byte(input byte_type b);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push    <= 1'b1;
      req_in_byte <= b;
      do begin
         @(posedge clock);
      end while (req_full);
      sb.add_source_byte(b, escape_on);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_escape(input bit value);
      wait_drained();
      @(negedge clock);
      csr_we            <= 1'b1;
      csr_escape_enable <= value;
      escape_on = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         push_byte(pick_byte());
      end
      req_push <= 1'b0;
   endtask

   initial begin
      byte_type directed[22];
      directed          = '{8'h00, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
                            8'h01, 8'h1F, 8'h20, 8'h22, 8'h5C, 8'h41, 8'h7E, 8'h7F,
                            8'h80, 8'hA0, 8'hB9, 8'hF0, 8'hFF, 8'hAA};
      sb                = new();
      escape_on         = 1'b1;
      calm              = 1'b0;
      hold_request      = 1'b0;
      hold_left         = 0;
      stall_count       = 0;
      reset             = 1'b1;
      req_push          = 1'b0;
      req_in_byte       = 8'h00;
      rsp_pop           = 1'b0;
      csr_we            = 1'b0;
      csr_escape_enable = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed edge bytes, first at the reset setting, then after a write
      foreach (directed[i]) begin
         push_byte(directed[i]);
      end
      req_push <= 1'b0;
      set_escape(1'b0);
      for (int i = 0; i < 6; i++) begin
         push_byte(directed[i * 3]);
      end
      req_push <= 1'b0;

      set_escape(1'b1);
      run_random(60);

      // hold the output off while the input keeps offering words
      set_escape(1'b0);
      hold_request = 1'b1;
      run_random(50);

      set_escape(1'b1);
      hold_request = 1'b1;
      run_random(40);

      set_escape(1'b0);
      calm = 1'b1;
      run_random(30);

      set_escape(1'b1);
      calm = 1'b1;
      run_random(30);
      calm = 1'b0;

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d words never arrived", sb.pending()));
      end
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
